// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define AST_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Consequent must hold in the cycle after the antecedent
`define AST_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// ----- rtl/core/nvqp_pkg.sv -----
// ----------------------------------------------------------------------------
// nvqp_pkg
// Types, constants and helper functions of the NVMe host queue pair engine.
// ----------------------------------------------------------------------------
package nvqp_pkg;

    // Ring geometry
    localparam int MAX_DEPTH = 64;
    localparam int PTR_W     = $clog2(MAX_DEPTH);
    localparam int ENTRY_W   = 7;

    // Reset values of the registers
    localparam logic [ENTRY_W-1:0] RESET_ENTRIES   = ENTRY_W'(MAX_DEPTH);
    localparam logic [7:0]         RESET_QNUM      = 8'd1;
    localparam logic [3:0]         RESET_STRIDE    = 4'd0;
    localparam logic [15:0]        DEFAULT_TIMEOUT = 16'd5000;

    // Doorbell layout
    localparam logic [25:0] DOORBELL_BASE = 26'h1000;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_QUEUE_ENTRIES = 2'd0;
    localparam logic [1:0] REG_QUEUE_NUMBER  = 2'd1;
    localparam logic [1:0] REG_DB_STRIDE     = 2'd2;
    localparam logic [1:0] REG_TIMEOUT       = 2'd3;

    typedef enum logic [1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_FATAL    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OC_SUBMITTED = 3'd0,
        OC_COMPLETED = 3'd1,
        OC_PENDING   = 3'd2,
        OC_TIMEOUT   = 3'd3,
        OC_FATAL     = 3'd4,
        OC_BUSY      = 3'd5,
        OC_NOTHING   = 3'd6
    } outcome_t;

    // One result item; field order matches the output tdata packing
    typedef struct packed {
        logic [9:0]       completion_status;
        logic             doorbell_write;
        logic [PTR_W-1:0] doorbell_value;
        logic [25:0]      doorbell_offset;
        logic [15:0]      assigned_cid;
        logic [PTR_W-1:0] sq_slot;
    } result_t;

    // Clamp the configured ring size into the supported range
    function automatic logic [ENTRY_W-1:0] ring_size(input logic [ENTRY_W-1:0] entries);
        logic [ENTRY_W-1:0] n;
        n = entries;
        if (n < ENTRY_W'(2))
            n = ENTRY_W'(2);
        if (n > ENTRY_W'(MAX_DEPTH))
            n = ENTRY_W'(MAX_DEPTH);
        return n;
    endfunction

    // Step a ring pointer, wrapping at the ring size
    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0]   ptr,
                                                      input logic [ENTRY_W-1:0] size);
        logic [ENTRY_W-1:0] n;
        n = ENTRY_W'(ptr) + ENTRY_W'(1);
        return (n >= size) ? '0 : n[PTR_W-1:0];
    endfunction

    // Byte offset of the tail (is_cq low) or head (is_cq high) doorbell
    function automatic logic [25:0] doorbell_at(input logic [7:0] qnum,
                                                input logic [3:0] code,
                                                input logic       is_cq);
        logic [4:0]  shamt;
        logic [25:0] idx;
        shamt = {1'b0, code} + 5'd2;
        idx   = 26'({qnum, is_cq});
        return DOORBELL_BASE + (idx << shamt);
    endfunction

endpackage

// ----- rtl/core/nvme_host_queue_pair_engine_top.sv -----
// ----------------------------------------------------------------------------
// nvme_host_queue_pair_engine_top
// Host side of one NVMe submission/completion queue pair, one command in flight.
// ----------------------------------------------------------------------------
// Each input item yields exactly one result item, in order. With the output
// free, the result is presented in the cycle after the item is accepted; the
// engine takes one item every cycle while s_tready is high. The event logic
// (pointer advance, doorbell offset shift-add, deadline decrement) settles
// within the accepting cycle and lands in the output buffer. This two-entry
// buffer (result register plus skid register) keeps s_tready high while only
// the result register is full; s_tready drops only while both are full. The
// user must write configuration registers through cfg_we/cfg_index/cfg_data
// only while no item is in progress; the engine does not enforce this.
module nvme_host_queue_pair_engine_top
    import nvqp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [0] entry_phase, [15:1] entry_status
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [5:0] sq_slot, [21:6] assigned_cid, [47:22] doorbell_offset,
    // [53:48] doorbell_value, [54] doorbell_write, [64:55] completion_status,
    // [71:65] zero
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser    // [2:0] outcome
);

    // Configuration registers
    logic [ENTRY_W-1:0] entries_reg;
    logic [7:0]         qnum_reg;
    logic [3:0]         stride_reg;
    logic [15:0]        timeout_reg;

    // Queue state
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic             phase_reg, phase_next;
    logic [15:0]      ident_reg, ident_next;
    logic             busy_reg, busy_next;
    logic [15:0]      ticks_reg, ticks_next;

    // Output buffer
    logic     out_valid_reg;
    result_t  out_data_reg;
    outcome_t out_oc_reg;
    logic     skid_valid_reg;
    result_t  skid_data_reg;
    outcome_t skid_oc_reg;

    logic               accept;
    logic               pop;
    cmd_t               cmd;
    logic               in_phase;
    logic [14:0]        in_status;
    logic [ENTRY_W-1:0] size;
    outcome_t           res_oc;
    result_t            res;

    assign cmd       = cmd_t'(s_tuser);
    assign in_phase  = s_tdata[0];
    assign in_status = s_tdata[15:1];
    assign size      = ring_size(entries_reg);

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= RESET_ENTRIES;
            qnum_reg    <= RESET_QNUM;
            stride_reg  <= RESET_STRIDE;
            timeout_reg <= DEFAULT_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_QUEUE_ENTRIES: entries_reg <= cfg_data[ENTRY_W-1:0];
                REG_QUEUE_NUMBER:  qnum_reg    <= cfg_data[7:0];
                REG_DB_STRIDE:     stride_reg  <= cfg_data[3:0];
                REG_TIMEOUT:       timeout_reg <= cfg_data;
                default:           entries_reg <= entries_reg;
            endcase
        end
    end

    // Work out the result and next state of the item on the input
    always_comb
    begin
        tail_next  = tail_reg;
        head_next  = head_reg;
        phase_next = phase_reg;
        ident_next = ident_reg;
        busy_next  = busy_reg;
        ticks_next = ticks_reg;
        res        = '0;
        res_oc     = OC_NOTHING;

        if (cmd == CMD_SUBMIT)
        begin
            if (busy_reg)
                res_oc = OC_BUSY;
            else
            begin
                res_oc              = OC_SUBMITTED;
                res.sq_slot         = tail_reg;
                res.assigned_cid    = ident_reg;
                ident_next          = ident_reg + 16'd1;
                tail_next           = ring_advance(tail_reg, size);
                res.doorbell_offset = doorbell_at(qnum_reg, stride_reg, 1'b0);
                res.doorbell_value  = tail_next;
                res.doorbell_write  = 1'b1;
                ticks_next          = timeout_reg;
                busy_next           = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            case (cmd)
                CMD_COMPLETE:
                begin
                    if (in_phase != phase_reg)
                        res_oc = OC_PENDING;
                    else
                    begin
                        head_next = ring_advance(head_reg, size);
                        if (head_next == '0)
                            phase_next = !phase_reg;
                        res_oc                = OC_COMPLETED;
                        res.doorbell_offset   = doorbell_at(qnum_reg, stride_reg, 1'b1);
                        res.doorbell_value    = head_next;
                        res.doorbell_write    = 1'b1;
                        res.completion_status = in_status[9:0];
                        busy_next             = 1'b0;
                    end
                end
                CMD_TICK:
                begin
                    if (ticks_reg == '0)
                    begin
                        res_oc    = OC_TIMEOUT;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        ticks_next = ticks_reg - 16'd1;
                        res_oc     = OC_PENDING;
                    end
                end
                default:
                begin
                    res_oc    = OC_FATAL;
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    // Hold queue state, advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg  <= '0;
            head_reg  <= '0;
            phase_reg <= 1'b1;
            ident_reg <= '0;
            busy_reg  <= 1'b0;
            ticks_reg <= '0;
        end
        else if (accept)
        begin
            tail_reg  <= tail_next;
            head_reg  <= head_next;
            phase_reg <= phase_next;
            ident_reg <= ident_next;
            busy_reg  <= busy_next;
            ticks_reg <= ticks_next;
        end
    end

    // Output buffer control: result register, skid register behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
                out_oc_reg   <= skid_oc_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= res;
                skid_oc_reg   <= res_oc;
            end
            else
            begin
                out_data_reg <= res;
                out_oc_reg   <= res_oc;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};
    assign m_tuser  = out_oc_reg;

endmodule

// ----- rtl/core/nvqp_checker.sv -----
// ----------------------------------------------------------------------------
// nvqp_checker
// Port-level checks of the NVMe host queue pair engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nvqp_checker
    import nvqp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic in_acc;
    logic out_pop;
    logic db_kind;
    logic sub_after_sub;

    assign in_acc        = s_tvalid && s_tready;
    assign out_pop       = m_tvalid && m_tready;
    assign db_kind       = (m_tuser == OC_SUBMITTED) || (m_tuser == OC_COMPLETED);
    assign sub_after_sub = in_acc && (s_tuser == CMD_SUBMIT) && out_pop
                           && (m_tuser == OC_SUBMITTED);

    // Stalled result must hold
    `AST_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Output is valid on the cycle after an accepted item
    `AST_NEXT(a_item_result, clk, rst_n, in_acc, m_tvalid)

    // Doorbell write goes with submitted and completed results only
    `AST_SAME(a_db_write, clk, rst_n, m_tvalid, m_tdata[54] == db_kind)

    // A submit taken while a submitted result leaves is rejected as busy
    `AST_NEXT(a_submit_seq, clk, rst_n, sub_after_sub, m_tuser != OC_SUBMITTED)

endmodule

bind nvme_host_queue_pair_engine_top nvqp_checker u_nvqp_checker (.*);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - NVMe host queue pair engine
// Drives submit, completion, tick and fatal items through the stream input,
// predicts every result from a behavioural copy of the queue pair state and
// compares each returned item field by field. Registers are reprogrammed
// between phases while the engine is idle.
// ----------------------------------------------------------------------------
module testbench;
    import nvqp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        cmd_t        cmd;
        logic        phase;
        logic [14:0] status;
    } host_item_t;

    typedef struct packed {
        outcome_t outcome;
        result_t  fields;
    } engine_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = REG_QUEUE_ENTRIES;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = CMD_SUBMIT;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    host_item_t     pending_items[$];
    engine_result_t expected_results[$];
    host_item_t     item_on_bus;
    int             errors = 0;

    // Traffic shaping controls, set between phases
    logic        tx_gaps   = 1'b1;
    logic        rx_stalls = 1'b1;
    logic        hold_req  = 1'b0;
    logic        hold_seen;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned rx_run;
    int unsigned hold_left;
    int unsigned quiet_cycles = 0;

    // Shadow registers and queue pair state
    logic [6:0]  ring_entries_reg = RESET_ENTRIES;
    logic [7:0]  qid_reg          = RESET_QNUM;
    logic [3:0]  stride_reg       = RESET_STRIDE;
    logic [15:0] timeout_reg      = DEFAULT_TIMEOUT;
    logic [5:0]  sq_tail          = '0;
    logic [5:0]  cq_head          = '0;
    logic        cq_phase         = 1'b1;
    logic [15:0] cid_next         = '0;
    logic        cmd_outstanding  = 1'b0;
    logic [15:0] ticks_remaining  = '0;

    nvme_host_queue_pair_engine_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Step a ring pointer, wrapping at the clamped ring size
    function automatic logic [5:0] next_slot(input logic [5:0] ptr);
        int unsigned depth;
        int unsigned nxt;
        depth = ring_entries_reg;
        if (depth < 2)
            depth = 2;
        if (depth > MAX_DEPTH)
            depth = MAX_DEPTH;
        nxt = ptr + 1;
        return (nxt >= depth) ? 6'd0 : 6'(nxt);
    endfunction

    // Byte offset of the tail (is_cq low) or head (is_cq high) doorbell
    function automatic logic [25:0] doorbell_addr(input logic is_cq);
        logic [63:0] spacing;
        logic [63:0] byte_off;
        spacing  = 64'd4 << stride_reg;
        byte_off = 64'(DOORBELL_BASE) + (64'(qid_reg) * 2 + 64'(is_cq)) * spacing;
        return byte_off[25:0];
    endfunction

    // Work out the result of one accepted item and advance the shadow state
    task automatic predict_engine_result(input host_item_t it);
        engine_result_t res;
        res = '0;
        res.outcome = OC_NOTHING;
        if (it.cmd == CMD_SUBMIT)
        begin
            if (cmd_outstanding)
                res.outcome = OC_BUSY;
            else
            begin
                res.outcome             = OC_SUBMITTED;
                res.fields.sq_slot      = sq_tail;
                res.fields.assigned_cid = cid_next;
                cid_next                = cid_next + 16'd1;
                sq_tail                 = next_slot(sq_tail);
                res.fields.doorbell_offset = doorbell_addr(1'b0);
                res.fields.doorbell_value  = sq_tail;
                res.fields.doorbell_write  = 1'b1;
                ticks_remaining         = timeout_reg;
                cmd_outstanding         = 1'b1;
            end
        end
        else if (!cmd_outstanding)
            res.outcome = OC_NOTHING;
        else if (it.cmd == CMD_COMPLETE)
        begin
            if (it.phase != cq_phase)
                res.outcome = OC_PENDING;
            else
            begin
                cq_head = next_slot(cq_head);
                if (cq_head == 6'd0)
                    cq_phase = ~cq_phase;
                res.outcome                  = OC_COMPLETED;
                res.fields.doorbell_offset   = doorbell_addr(1'b1);
                res.fields.doorbell_value    = cq_head;
                res.fields.doorbell_write    = 1'b1;
                res.fields.completion_status = it.status[9:0];
                cmd_outstanding              = 1'b0;
            end
        end
        else if (it.cmd == CMD_TICK)
        begin
            if (ticks_remaining == 16'd0)
            begin
                res.outcome     = OC_TIMEOUT;
                cmd_outstanding = 1'b0;
            end
            else
            begin
                ticks_remaining = ticks_remaining - 16'd1;
                res.outcome     = OC_PENDING;
            end
        end
        else
        begin
            res.outcome     = OC_FATAL;
            cmd_outstanding = 1'b0;
        end
        expected_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: launch queued items in bursts, hold each until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= CMD_SUBMIT;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_engine_result(item_on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {item_on_bus.status, item_on_bus.phase};
                    s_tuser  <= item_on_bus.cmd;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= tx_gaps ? $urandom_range(1, 6) : 0;
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random ready pattern, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            rx_run    <= 0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end
        else if (!rx_stalls)
            m_tready <= 1'b1;
        else if (rx_run != 0)
            rx_run <= rx_run - 1;
        else
        begin
            m_tready <= ~m_tready;
            rx_run   <= m_tready ? $urandom_range(0, 4) : $urandom_range(0, 7);
        end
    end

    // Monitor: compare each returned item with the oldest prediction
    always @(posedge clk)
    begin
        engine_result_t want;
        result_t        got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual outcome %0d data %h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                got  = result_t'(m_tdata[64:0]);
                check_field("outcome", want.outcome, m_tuser);
                check_field("sq_slot", want.fields.sq_slot, got.sq_slot);
                check_field("assigned_cid", want.fields.assigned_cid, got.assigned_cid);
                check_field("doorbell_offset", want.fields.doorbell_offset,
                            got.doorbell_offset);
                check_field("doorbell_value", want.fields.doorbell_value,
                            got.doorbell_value);
                check_field("doorbell_write", want.fields.doorbell_write,
                            got.doorbell_write);
                check_field("completion_status", want.fields.completion_status,
                            got.completion_status);
                check_field("padding", 32'd0, m_tdata[71:65]);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input cmd_t c, input logic ph, input logic [14:0] st);
        pending_items.push_back({c, ph, st});
    endtask

    task automatic push_noise_fields(input cmd_t c);
        push_item(c, 1'($urandom_range(0, 1)), 15'($urandom_range(0, 32767)));
    endtask

    // Wait until every item is taken and every result has come back
    task automatic settle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_QUEUE_ENTRIES: ring_entries_reg = value[6:0];
            REG_QUEUE_NUMBER:  qid_reg          = value[7:0];
            REG_DB_STRIDE:     stride_reg       = value[3:0];
            REG_TIMEOUT:       timeout_reg      = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One command life cycle with random content, or a stray item
    task automatic push_sequence(inout int counted);
        int tick_max;
        int n_ticks;
        if ($urandom_range(0, 99) < 80)
        begin
            tick_max = (timeout_reg < 10) ? int'(timeout_reg) + 2 : 6;
            n_ticks  = $urandom_range(0, tick_max);
            push_noise_fields(CMD_SUBMIT);
            counted++;
            if ($urandom_range(0, 5) == 0)
            begin
                push_noise_fields(CMD_SUBMIT);
                counted++;
            end
            repeat (n_ticks)
            begin
                push_noise_fields(CMD_TICK);
                counted++;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                push_noise_fields(CMD_FATAL);
                counted++;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    push_noise_fields(CMD_COMPLETE);
                    counted++;
                end
            end
        end
        else
        begin
            push_noise_fields(cmd_t'($urandom_range(0, 3)));
            counted++;
        end
    endtask

    initial
    begin
        int counted;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Idle items, busy submit, phase mismatch, tick, full status mask, fatal
        push_item(CMD_COMPLETE, 1'b1, 15'h7FFF);
        push_item(CMD_TICK, 1'b0, 15'h0000);
        push_item(CMD_FATAL, 1'b1, 15'h7FFF);
        push_item(CMD_SUBMIT, 1'b0, 15'h0000);
        push_item(CMD_SUBMIT, 1'b1, 15'h7FFF);
        push_item(CMD_COMPLETE, 1'b0, 15'h7FFF);
        push_item(CMD_TICK, 1'b1, 15'h7FFF);
        push_item(CMD_COMPLETE, 1'b1, 15'h7FFF);
        push_item(CMD_SUBMIT, 1'b0, 15'h0000);
        push_item(CMD_FATAL, 1'b0, 15'h0000);
        settle();

        // Smallest ring, largest doorbell offset, zero timeout; tail is beyond the ring
        write_reg(REG_QUEUE_ENTRIES, 16'd2);
        write_reg(REG_QUEUE_NUMBER, 16'd255);
        write_reg(REG_DB_STRIDE, 16'd15);
        write_reg(REG_TIMEOUT, 16'd0);
        push_item(CMD_SUBMIT, 1'b0, 15'h0000);
        push_item(CMD_TICK, 1'b0, 15'h0000);
        push_item(CMD_SUBMIT, 1'b0, 15'h0000);
        push_item(CMD_COMPLETE, 1'b1, 15'h0000);
        push_item(CMD_SUBMIT, 1'b0, 15'h0000);
        push_item(CMD_COMPLETE, 1'b1, 15'h2AAA);
        push_item(CMD_COMPLETE, 1'b0, 15'h55A5);
        settle();

        // One tick of grace before the timeout
        write_reg(REG_TIMEOUT, 16'd1);
        push_item(CMD_SUBMIT, 1'b0, 15'h0000);
        push_item(CMD_TICK, 1'b0, 15'h0000);
        push_item(CMD_TICK, 1'b0, 15'h0000);
        settle();

        // Random phases, each with its own register setting and traffic shape
        for (int phase_idx = 0; phase_idx < 8; phase_idx++)
        begin
            case (phase_idx)
                0:
                begin
                    write_reg(REG_QUEUE_ENTRIES, 16'd64);
                    write_reg(REG_QUEUE_NUMBER, 16'($urandom_range(0, 255)));
                    write_reg(REG_DB_STRIDE, 16'($urandom_range(0, 15)));
                    write_reg(REG_TIMEOUT, 16'd3);
                    tx_gaps   <= 1'b1;
                    rx_stalls <= 1'b1;
                end
                1:
                begin
                    write_reg(REG_QUEUE_ENTRIES, 16'd3);
                    write_reg(REG_QUEUE_NUMBER, 16'd0);
                    write_reg(REG_DB_STRIDE, 16'd0);
                    write_reg(REG_TIMEOUT, 16'($urandom_range(0, 8)));
                    tx_gaps   <= 1'b0;
                    rx_stalls <= 1'b0;
                end
                2:
                begin
                    write_reg(REG_QUEUE_ENTRIES, 16'd0);
                    write_reg(REG_TIMEOUT, 16'd2);
                    tx_gaps   <= 1'b0;
                    rx_stalls <= 1'b1;
                    hold_req  <= ~hold_req;
                end
                3:
                begin
                    write_reg(REG_QUEUE_ENTRIES, 16'd127);
                    write_reg(REG_QUEUE_NUMBER, 16'd255);
                    write_reg(REG_DB_STRIDE, 16'd15);
                    write_reg(REG_TIMEOUT, 16'd65535);
                    tx_gaps   <= 1'b1;
                    rx_stalls <= 1'b1;
                end
                default:
                begin
                    write_reg(REG_QUEUE_ENTRIES, ($urandom_range(0, 3) == 0) ?
                              16'($urandom_range(0, 127)) : 16'($urandom_range(1, 9)));
                    write_reg(REG_QUEUE_NUMBER, 16'($urandom));
                    write_reg(REG_DB_STRIDE, 16'($urandom));
                    write_reg(REG_TIMEOUT, 16'($urandom_range(0, 12)));
                    tx_gaps   <= 1'($urandom_range(0, 1));
                    rx_stalls <= 1'($urandom_range(0, 1));
                end
            endcase
            counted = 0;
            while (counted < 240)
                push_sequence(counted);
            settle();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
